// ===== rtl/mips_integer_execute_unit_macros.svh =====
// Assertion macros for the MIPS integer execute unit
`ifndef MIPS_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MIEU_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define MIEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error("check failed");
`else
`define MIEU_ASSERT_IMPL(label, clk, rst_n, prop)
`define MIEU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mieu_pkg.sv =====
// Shared types, operation codes and helpers for the MIPS integer execute unit
package mieu_pkg;

  localparam int QueueDepth = 2;
  localparam int RegCount = 32;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [31:0] TOP_NIBBLE = 32'hF000_0000;
  localparam logic [31:0] LOW_28     = 32'h0FFF_FFFF;
  localparam logic [31:0] UPPER_HALF = 32'hFFFF_0000;

  localparam logic [5:0] OP_BLTZ = 6'd0, OP_BGEZ = 6'd1, OP_BLTZAL = 6'd2, OP_BGEZAL = 6'd3;
  localparam logic [5:0] OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLEZ = 6'd6, OP_BGTZ = 6'd7;
  localparam logic [5:0] OP_ADDI = 6'd8, OP_ADDIU = 6'd9, OP_SLTI = 6'd10, OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI = 6'd12, OP_ORI = 6'd13, OP_XORI = 6'd14, OP_LUI = 6'd15;
  localparam logic [5:0] OP_J = 6'd16, OP_JAL = 6'd17, OP_SLL = 6'd18, OP_SRL = 6'd19;
  localparam logic [5:0] OP_SRA = 6'd20, OP_SLLV = 6'd21, OP_SRLV = 6'd22, OP_SRAV = 6'd23;
  localparam logic [5:0] OP_JR = 6'd24, OP_JALR = 6'd25, OP_MFHI = 6'd26, OP_MTHI = 6'd27;
  localparam logic [5:0] OP_MFLO = 6'd28, OP_MTLO = 6'd29, OP_MULT = 6'd30, OP_MULTU = 6'd31;
  localparam logic [5:0] OP_DIV = 6'd32, OP_DIVU = 6'd33, OP_ADD = 6'd34, OP_ADDU = 6'd35;
  localparam logic [5:0] OP_SUB = 6'd36, OP_SUBU = 6'd37, OP_AND = 6'd38, OP_OR = 6'd39;
  localparam logic [5:0] OP_XOR = 6'd40, OP_SLT = 6'd41, OP_SLTU = 6'd42;

  // Decoded instruction handed from front to back
  typedef struct packed {
    logic [5:0]  op;
    logic        invalid;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [15:0] imm;
    logic [25:0] tgt;
  } instr_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== rtl/mips_integer_execute_unit.sv =====
// Top level of the MIPS I integer execute unit
// Channel | Handshake          | Payload
// in      | in_push / in_full  | operation, src_reg, second_reg, dest_reg, shift_amount, ...
// out     | out_pop / out_empty| status, pc_now, pc_following
// Simple instructions pass through dispatch, operand read and execute in the back end.
// MULT/MULTU/DIV/DIVU go through the shared unit, which retires one bit per cycle.
// Reset is synchronous, active low; register file reads zero until written.
// A full result register stalls execution; the front queue keeps accepting meanwhile.
module mips_integer_execute_unit import mieu_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [5:0]  in_operation,
  input  logic [4:0]  in_src_reg,
  input  logic [4:0]  in_second_reg,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_shift_amount,
  input  logic [15:0] in_immediate,
  input  logic [25:0] in_jump_target,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [31:0] out_pc_now,
  output logic [31:0] out_pc_following
);
  logic   dq_valid, dq_take;
  instr_t dq_instr;

  mieu_decode #(.Depth(QDepth)) u_dec (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_src_reg(in_src_reg), .in_second_reg(in_second_reg),
    .in_dest_reg(in_dest_reg), .in_shift_amount(in_shift_amount),
    .in_immediate(in_immediate), .in_jump_target(in_jump_target),
    .dq_valid(dq_valid), .dq_instr(dq_instr), .dq_take(dq_take)
  );

  mieu_execute u_exe (
    .clk(clk), .rst_n(rst_n), .dq_valid(dq_valid), .dq_instr(dq_instr), .dq_take(dq_take),
    .out_empty(out_empty), .out_pop(out_pop), .out_status(out_status),
    .out_pc_now(out_pc_now), .out_pc_following(out_pc_following)
  );

endmodule

// ===== rtl/mieu_decode.sv =====
// Front end: accepts instructions, checks reserved fields, queues them
module mieu_decode import mieu_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [5:0]  in_operation,
  input  logic [4:0]  in_src_reg,
  input  logic [4:0]  in_second_reg,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_shift_amount,
  input  logic [15:0] in_immediate,
  input  logic [25:0] in_jump_target,
  output logic        dq_valid,
  output instr_t      dq_instr,
  input  logic        dq_take
);
  `include "mips_integer_execute_unit_macros.svh"

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  instr_t           mem_r [Depth];
  logic [PtrW-1:0]  wp_r, rp_r;
  logic [PtrW:0]    cnt_r;
  logic             inv;
  logic             push_ok, pop_ok;
  instr_t           dec;

  // Classify reserved fields
  always_comb begin
    inv = 1'b0;
    case (in_operation) inside
      OP_BLEZ, OP_BGTZ:         inv = in_second_reg != 5'd0;
      OP_LUI, OP_SLL, OP_SRL, OP_SRA: inv = in_src_reg != 5'd0;
      OP_JR:   inv = (in_second_reg | in_dest_reg | in_shift_amount) != 5'd0;
      OP_JALR: inv = (in_second_reg | in_shift_amount) != 5'd0;
      OP_MFHI, OP_MFLO: inv = (in_src_reg | in_second_reg | in_shift_amount) != 5'd0;
      OP_MTHI, OP_MTLO: inv = (in_dest_reg | in_second_reg | in_shift_amount) != 5'd0;
      OP_MULT, OP_MULTU, OP_DIV, OP_DIVU: inv = (in_dest_reg | in_shift_amount) != 5'd0;
      [OP_SLLV:OP_SRAV], [OP_ADD:OP_SLTU]: inv = in_shift_amount != 5'd0;
      [OP_BLTZ:OP_BGEZAL], OP_BEQ, OP_BNE, [OP_ADDI:OP_XORI], OP_J, OP_JAL: inv = 1'b0;
      default: inv = 1'b1;
    endcase
  end

  assign dec = '{op: in_operation, invalid: inv, rs: in_src_reg, rt: in_second_reg,
                 rd: in_dest_reg, sa: in_shift_amount, imm: in_immediate, tgt: in_jump_target};

  assign in_full  = cnt_r == (PtrW+1)'(Depth);
  assign dq_valid = cnt_r != '0;
  assign dq_instr = mem_r[rp_r];
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = dq_take && dq_valid;

  // Store request
  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= dec;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= (wp_r == PtrW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop_ok)  rp_r <= (rp_r == PtrW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push_ok) - (PtrW+1)'(pop_ok);
    end
  end

  `MIEU_ASSERT_IMPL(a_cnt_bound, clk, rst_n, cnt_r <= (PtrW+1)'(Depth))
  `MIEU_ASSERT_NEXT(a_cnt_up, clk, rst_n, push_ok && !pop_ok, cnt_r == $past(cnt_r) + 1'b1)
  `MIEU_ASSERT_NEXT(a_cnt_dn, clk, rst_n, pop_ok && !push_ok, cnt_r == $past(cnt_r) - 1'b1)

endmodule

// ===== rtl/mieu_muldiv.sv =====
// Iterative multiply/divide unit, one bit per cycle, unsigned magnitudes
module mieu_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic [31:0] opa,
  input  logic [31:0] opb,
  output logic        busy,
  output logic        done,
  output logic [31:0] res_hi,
  output logic [31:0] res_lo
);
  logic [5:0]  cnt_r;
  logic        busy_r, done_r, div_r;
  logic [31:0] b_r;
  logic [63:0] acc_r;
  logic [32:0] sum;
  logic [32:0] diff;

  assign busy   = busy_r;
  assign done   = done_r;
  assign res_hi = acc_r[63:32];
  assign res_lo = acc_r[31:0];

  assign sum  = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, b_r} : 33'd0);
  assign diff = {acc_r[63:31]} - {1'b0, b_r};

  // Iterate shift-add or shift-subtract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1; cnt_r <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0; done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      div_r <= is_div; b_r <= opb; acc_r <= {32'd0, opa};
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[32]) acc_r <= {diff[31:0], acc_r[30:0], 1'b1};
        else           acc_r <= {acc_r[62:0], 1'b0};
      end else begin
        acc_r <= {sum, acc_r[31:1]};
      end
    end
  end

endmodule

// ===== rtl/mieu_execute.sv =====
// Back end: register file, HI/LO, PC and result register
module mieu_execute import mieu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        dq_valid,
  input  instr_t      dq_instr,
  output logic        dq_take,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [31:0] out_pc_now,
  output logic [31:0] out_pc_following
);
  `include "mips_integer_execute_unit_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0, S_READ = 2'd1, S_EXEC = 2'd2, S_MD = 2'd3;

  logic [1:0]  state_r;
  logic [31:0] regs_r [RegCount];
  logic [31:0] hi_r, lo_r, pc_r, npc_r;
  logic [RegCount-1:0] vld_r;
  instr_t      ins_r;
  logic [31:0] a_r, b_r;
  logic        out_full_r;
  logic        out_full_nxt, fin_exec;
  logic [1:0]  st_r;
  logic [31:0] opc_r, opn_r;
  logic        neg_q_r, neg_r_r;

  logic [31:0] imm_s, r, tgt_npc, br_npc, adv_npc, new_npc;
  logic        wr, taken, jmp, is_md, is_div, sgn;
  logic [4:0]  wa;
  logic [1:0]  st;
  logic [32:0] ltu;
  logic        md_busy, md_done, md_start;
  logic [31:0] md_hi, md_lo, ma, mb;

  assign imm_s   = sext16(ins_r.imm);
  assign adv_npc = npc_r + 32'd4;
  assign br_npc  = npc_r + {imm_s[29:0], 2'b00};
  assign tgt_npc = (npc_r & TOP_NIBBLE) | ({4'd0, ins_r.tgt, 2'b00} & LOW_28);
  assign is_md   = ins_r.op == OP_MULT || ins_r.op == OP_MULTU ||
                   ins_r.op == OP_DIV  || ins_r.op == OP_DIVU;
  assign is_div  = ins_r.op == OP_DIV || ins_r.op == OP_DIVU;
  assign sgn     = ins_r.op == OP_MULT || ins_r.op == OP_DIV;

  // Compute result, status and next PC combinationally
  always_comb begin
    wr = 1'b0; wa = ins_r.rd; r = '0; taken = 1'b0; jmp = 1'b0; new_npc = tgt_npc;
    st = ins_r.invalid ? ST_INVALID : ST_OK;
    ltu = '0;
    case (ins_r.op)
      OP_BLTZ:   taken = a_r[31];
      OP_BGEZ:   taken = !a_r[31];
      OP_BLTZAL: begin taken = a_r[31];  wr = 1'b1; wa = 5'd31; r = pc_r + 32'd8; end
      OP_BGEZAL: begin taken = !a_r[31]; wr = 1'b1; wa = 5'd31; r = pc_r + 32'd8; end
      OP_BEQ:    taken = a_r == b_r;
      OP_BNE:    taken = a_r != b_r;
      OP_BLEZ:   taken = a_r[31] || a_r == '0;
      OP_BGTZ:   taken = !a_r[31] && a_r != '0;
      OP_ADDI, OP_ADDIU: begin
        r = a_r + imm_s; wr = 1'b1; wa = ins_r.rt;
        if (ins_r.op == OP_ADDI && a_r[31] == imm_s[31] && r[31] != a_r[31]) st = ST_OVERFLOW;
      end
      OP_SLTI:  begin wr = 1'b1; wa = ins_r.rt; r = {31'd0, $signed(a_r) < $signed(imm_s)}; end
      OP_SLTIU: begin wr = 1'b1; wa = ins_r.rt; r = {31'd0, a_r < imm_s}; end
      OP_ANDI:  begin wr = 1'b1; wa = ins_r.rt; r = a_r & {16'd0, ins_r.imm}; end
      OP_ORI:   begin wr = 1'b1; wa = ins_r.rt; r = a_r | {16'd0, ins_r.imm}; end
      OP_XORI:  begin wr = 1'b1; wa = ins_r.rt; r = a_r ^ {16'd0, ins_r.imm}; end
      OP_LUI:   begin wr = 1'b1; wa = ins_r.rt; r = {ins_r.imm, 16'd0}; end
      OP_J:     jmp = 1'b1;
      OP_JAL:   begin jmp = 1'b1; wr = 1'b1; wa = 5'd31; r = pc_r + 32'd8; end
      OP_SLL:   begin wr = 1'b1; r = b_r << ins_r.sa; end
      OP_SRL:   begin wr = 1'b1; r = b_r >> ins_r.sa; end
      OP_SRA:   begin wr = 1'b1; r = 32'($signed(b_r) >>> ins_r.sa); end
      OP_SLLV:  begin wr = 1'b1; r = b_r << a_r[4:0]; end
      OP_SRLV:  begin wr = 1'b1; r = b_r >> a_r[4:0]; end
      OP_SRAV:  begin wr = 1'b1; r = 32'($signed(b_r) >>> a_r[4:0]); end
      OP_JR:    begin jmp = 1'b1; new_npc = a_r; end
      OP_JALR:  begin jmp = 1'b1; new_npc = a_r; wr = 1'b1; r = pc_r + 32'd8; end
      OP_MFHI:  begin wr = 1'b1; r = hi_r; end
      OP_MFLO:  begin wr = 1'b1; r = lo_r; end
      OP_ADD, OP_ADDU: begin
        wr = 1'b1; r = a_r + b_r;
        if (ins_r.op == OP_ADD && !ins_r.invalid && a_r[31] == b_r[31] && r[31] != a_r[31])
          st = ST_OVERFLOW;
      end
      OP_SUB, OP_SUBU: begin
        wr = 1'b1; r = a_r - b_r;
        if (ins_r.op == OP_SUB && !ins_r.invalid && a_r[31] != b_r[31] && r[31] != a_r[31])
          st = ST_OVERFLOW;
      end
      OP_AND:  begin wr = 1'b1; r = a_r & b_r; end
      OP_OR:   begin wr = 1'b1; r = a_r | b_r; end
      OP_XOR:  begin wr = 1'b1; r = a_r ^ b_r; end
      OP_SLT:  begin wr = 1'b1; r = {31'd0, $signed(a_r) < $signed(b_r)}; end
      OP_SLTU: begin ltu = {1'b0, a_r} - {1'b0, b_r}; wr = 1'b1; r = {31'd0, ltu[32]}; end
      default: ;
    endcase
    if (!jmp) new_npc = taken ? br_npc : adv_npc;
  end

  assign ma = (sgn && a_r[31]) ? 32'd0 - a_r : a_r;
  assign mb = (sgn && b_r[31]) ? 32'd0 - b_r : b_r;
  assign md_start = state_r == S_EXEC && (!out_full_r || out_pop) && is_md && st == ST_OK
                    && !md_busy && !(is_div && b_r == '0);

  mieu_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start), .is_div(is_div), .opa(ma), .opb(mb),
    .busy(md_busy), .done(md_done), .res_hi(md_hi), .res_lo(md_lo)
  );

  // Fill the result register on completion, drain it on pop
  assign fin_exec     = state_r == S_EXEC && (!out_full_r || out_pop) && !md_start;
  assign out_full_nxt = fin_exec || (state_r == S_MD && md_done) || (out_full_r && !out_pop);

  assign dq_take    = state_r == S_IDLE && dq_valid;
  assign out_empty  = !out_full_r;
  assign out_status = st_r;
  assign out_pc_now = opc_r;
  assign out_pc_following = opn_r;

  // Sequence one instruction at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; vld_r <= '0; out_full_r <= 1'b0;
      hi_r <= '0; lo_r <= '0; pc_r <= '0; npc_r <= 32'd4;
    end else begin
      out_full_r <= out_full_nxt;
      case (state_r)
        S_IDLE: if (dq_valid) state_r <= S_READ;
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          if (!out_full_r || out_pop) begin
            if (st == ST_OK && md_start) begin
              state_r <= S_MD;
              neg_q_r <= sgn && (a_r[31] != b_r[31]);
              neg_r_r <= sgn && a_r[31];
            end else begin
              state_r <= S_IDLE;
              st_r <= st;
              if (st == ST_OK) begin
                opc_r <= npc_r; opn_r <= new_npc;
                pc_r <= npc_r; npc_r <= new_npc;
                if (wr && wa != 5'd0) vld_r[wa] <= 1'b1;
                if (ins_r.op == OP_MTHI) hi_r <= a_r;
                if (ins_r.op == OP_MTLO) lo_r <= a_r;
              end else begin
                opc_r <= pc_r; opn_r <= npc_r;
              end
            end
          end
        end
        S_MD: if (md_done) begin
          state_r <= S_IDLE;
          st_r <= ST_OK;
          opc_r <= npc_r; opn_r <= adv_npc; pc_r <= npc_r; npc_r <= adv_npc;
          if (is_div) begin
            lo_r <= neg_q_r ? 32'd0 - md_lo : md_lo;
            hi_r <= neg_r_r ? 32'd0 - md_hi : md_hi;
          end else begin
            {hi_r, lo_r} <= neg_q_r ? 64'd0 - {md_hi, md_lo} : {md_hi, md_lo};
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Latch instruction, read operands, write register file
  always_ff @(posedge clk) begin
    if (dq_take) ins_r <= dq_instr;
    if (state_r == S_READ) begin
      a_r <= vld_r[ins_r.rs] ? regs_r[ins_r.rs] : 32'd0;
      b_r <= vld_r[ins_r.rt] ? regs_r[ins_r.rt] : 32'd0;
    end
    if (state_r == S_EXEC && (!out_full_r || out_pop) && st == ST_OK && !md_start
        && wr && wa != 5'd0)
      regs_r[wa] <= r;
  end

  `MIEU_ASSERT_NEXT(a_take_read, clk, rst_n, dq_take, state_r == S_READ)
  `MIEU_ASSERT_IMPL(a_zero_invalid, clk, rst_n, !vld_r[0])
  `MIEU_ASSERT_NEXT(a_md_busy, clk, rst_n, md_start, state_r == S_MD && md_busy)

endmodule
